// ===== src/heading_pid_rotate_with_settle_assert.svh =====
// assertion macros for the heading controller
`ifndef HEADING_PID_ROTATE_WITH_SETTLE_ASSERT_SVH
`define HEADING_PID_ROTATE_WITH_SETTLE_ASSERT_SVH

// same-cycle implication
`define HPRS_AST_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heading controller check failed");

// next-cycle implication
`define HPRS_AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heading controller check failed");

`endif

// ===== src/hprs_pkg.sv =====
`default_nettype none
package hprs_pkg;

    localparam logic signed [17:0] PI_Q     = 18'sd25736;
    localparam logic signed [17:0] TWO_PI_Q = 18'sd51472;
    localparam logic signed [18:0] DRIVE_MAX = 19'sd1023;
    localparam logic signed [18:0] DRIVE_MIN = -19'sd1023;

    typedef enum logic [2:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_INT_LIMIT = 3'd3,
        REG_TOLERANCE = 3'd4,
        REG_SETTLE    = 3'd5
    } hprs_reg_idx_t;

    typedef struct packed {
        logic [11:0] gain_p;
        logic [11:0] gain_i;
        logic [11:0] gain_d;
        logic [12:0] int_limit;
        logic [12:0] tolerance;
        logic [3:0]  settle_steps;
    } hprs_cfg_t;

    typedef struct packed {
        logic signed [10:0] drive_value;
        logic signed [15:0] heading_error;
        logic               stop_motor;
        logic               done_res;
    } hprs_result_t;

endpackage
`default_nettype wire

// ===== src/hprs_front.sv =====
`default_nettype none
module hprs_front (
    input  wire logic signed [15:0] target_heading,
    input  wire logic signed [15:0] current_heading,
    output logic signed [15:0]      heading_error
);
    import hprs_pkg::*;

    function automatic logic signed [17:0] wrap_once(input logic signed [17:0] a);
        logic signed [17:0] r;
        r = a;
        if (r > PI_Q) r = r - TWO_PI_Q;
        if (r < -PI_Q) r = r + TWO_PI_Q;
        return r;
    endfunction

    logic signed [17:0] tgt_w;
    logic signed [17:0] diff;
    logic signed [17:0] err_w;

    always_comb
    begin
        tgt_w = wrap_once(18'(target_heading));
        diff  = tgt_w - 18'(current_heading);
        err_w = wrap_once(diff);
    end

    // wrapped error always within +/-pi
    assign heading_error = err_w[15:0];

endmodule
`default_nettype wire

// ===== src/hprs_fifo.sv =====
`default_nettype none
module hprs_fifo (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire logic signed [15:0] push_data,
    output logic                    full,
    input  wire logic               pop,
    output logic                    not_empty,
    output logic signed [15:0]      pop_data
);
    logic signed [15:0] mem_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== src/hprs_back.sv =====
`default_nettype none
module hprs_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hprs_pkg::hprs_cfg_t cfg,
    input  wire logic               in_valid,
    input  wire logic signed [15:0] in_err,
    output logic                    in_pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output hprs_pkg::hprs_result_t  out_data
);
    import hprs_pkg::*;

    // controller state
    logic signed [15:0] prev_reg, prev_next;
    logic signed [13:0] integ_reg, integ_next;
    logic [3:0]         settle_reg, settle_next;

    // stage 1: error terms
    logic               v1_reg;
    logic signed [15:0] s1_err_reg;
    logic signed [13:0] s1_int_reg;
    logic signed [16:0] s1_der_reg;
    logic               s1_done_reg;

    // stage 2: products
    logic               v2_reg;
    logic signed [28:0] s2_pp_reg;
    logic signed [26:0] s2_pi_reg;
    logic signed [29:0] s2_pd_reg;
    logic signed [15:0] s2_err_reg;
    logic               s2_done_reg;

    // stage 3: output register
    logic               v3_reg;
    hprs_result_t       out_reg, out_next;

    logic load1, load2, load3;
    logic signed [16:0] int_sum, int_lim, int_clamped;
    logic signed [16:0] deriv;
    logic signed [16:0] mag;
    logic               in_tol, done;
    logic signed [31:0] sum;
    logic signed [31:0] shifted;

    assign load3  = !v3_reg || out_ready;
    assign load2  = !v2_reg || load3;
    assign load1  = !v1_reg || load2;
    assign in_pop = in_valid && load1;

    always_comb
    begin
        int_sum = 17'(integ_reg) + 17'(in_err);
        int_lim = 17'({1'b0, cfg.int_limit});
        if (int_sum > int_lim)
            int_clamped = int_lim;
        else if (int_sum < -int_lim)
            int_clamped = -int_lim;
        else
            int_clamped = int_sum;
        deriv  = 17'(in_err) - 17'(prev_reg);
        mag    = in_err[15] ? -17'(in_err) : 17'(in_err);
        in_tol = mag < 17'({1'b0, cfg.tolerance});
        done   = 1'b0;
        prev_next   = in_err;
        integ_next  = int_clamped[13:0];
        settle_next = settle_reg;
        if (in_tol)
        begin
            if (settle_reg < cfg.settle_steps)
                settle_next = settle_reg + 4'd1;
            else
            begin
                done        = 1'b1;
                prev_next   = '0;
                integ_next  = '0;
                settle_next = '0;
            end
        end
    end

    always_comb
    begin
        sum     = 32'(s2_pp_reg) + 32'(s2_pi_reg) + 32'(s2_pd_reg);
        shifted = sum >>> 13;
        if (shifted > 32'(DRIVE_MAX))
            out_next.drive_value = DRIVE_MAX[10:0];
        else if (shifted < 32'(DRIVE_MIN))
            out_next.drive_value = DRIVE_MIN[10:0];
        else
            out_next.drive_value = shifted[10:0];
        out_next.heading_error = s2_done_reg ? 16'sd0 : s2_err_reg;
        out_next.stop_motor    = s2_done_reg;
        out_next.done_res      = s2_done_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            integ_reg  <= '0;
            settle_reg <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
        end
        else
        begin
            if (in_pop)
            begin
                prev_reg   <= prev_next;
                integ_reg  <= integ_next;
                settle_reg <= settle_next;
            end
            if (load1) v1_reg <= in_valid;
            if (load2) v2_reg <= v1_reg;
            if (load3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            s1_err_reg  <= in_err;
            s1_int_reg  <= int_clamped[13:0];
            s1_der_reg  <= deriv;
            s1_done_reg <= done;
        end
        if (load2)
        begin
            s2_pp_reg   <= $signed({1'b0, cfg.gain_p}) * s1_err_reg;
            s2_pi_reg   <= $signed({1'b0, cfg.gain_i}) * s1_int_reg;
            s2_pd_reg   <= $signed({1'b0, cfg.gain_d}) * s1_der_reg;
            s2_err_reg  <= s1_err_reg;
            s2_done_reg <= s1_done_reg;
        end
        if (load3)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = out_reg;

endmodule
`default_nettype wire

// ===== src/heading_pid_rotate_with_settle.sv =====
// channel   dir  handshake                     payload
// s_*       in   s_tvalid / s_tready           s_tdata[31:0]
// m_*       out  m_tvalid / m_tready           m_tdata[31:0]
// cfg_*     in   cfg_valid / cfg_ready         cfg_index[2:0], cfg_data[12:0]
//
// One beat per cycle sustained while m_tready is high; each result passes the error queue, then stages 1, 2 and 3.
// The PID datapath is a three-stage pipeline behind a two-entry error queue.
// Reset loads the default gains and limits and clears integral, previous error, settle count.
// A stalled m_* side fills the pipeline and queue, then drops s_tready.
// cfg_ready is always high.
`default_nettype none
module heading_pid_rotate_with_settle (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // target_heading[15:0], current_heading[31:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // drive_value[10:0], heading_error[26:11],
                                        // stop_motor[27], done_res[28], zero[31:29]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [12:0] cfg_data
);
    import hprs_pkg::*;

    hprs_cfg_t          cfg_reg, cfg_next;
    logic signed [15:0] front_err;
    logic               q_full, q_not_empty, q_pop;
    logic signed [15:0] q_data;
    hprs_result_t       res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_GAIN_P:    cfg_next.gain_p       = cfg_data[11:0];
                REG_GAIN_I:    cfg_next.gain_i       = cfg_data[11:0];
                REG_GAIN_D:    cfg_next.gain_d       = cfg_data[11:0];
                REG_INT_LIMIT: cfg_next.int_limit    = cfg_data;
                REG_TOLERANCE: cfg_next.tolerance    = cfg_data;
                REG_SETTLE:    cfg_next.settle_steps = cfg_data[3:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_p       <= 12'd500;
            cfg_reg.gain_i       <= 12'd800;
            cfg_reg.gain_d       <= 12'd400;
            cfg_reg.int_limit    <= 13'd2144;
            cfg_reg.tolerance    <= 13'd410;
            cfg_reg.settle_steps <= 4'd3;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    hprs_front u_front (
        .target_heading  (s_tdata[15:0]),
        .current_heading (s_tdata[31:16]),
        .heading_error   (front_err)
    );

    assign s_tready = !q_full;

    hprs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid),
        .push_data (front_err),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_data)
    );

    hprs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (q_not_empty),
        .in_err    (q_data),
        .in_pop    (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res)
    );

    assign m_tdata = {3'b000, res.done_res, res.stop_motor, res.heading_error,
                      res.drive_value};

endmodule
`default_nettype wire

// ===== src/hprs_checker.sv =====
`default_nettype none
`include "heading_pid_rotate_with_settle_assert.svh"
module hprs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);
    `HPRS_AST_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `HPRS_AST_NOW(a_stop_eq_done, m_tvalid, m_tdata[27] == m_tdata[28])
    `HPRS_AST_NOW(a_done_zero_err, m_tvalid && m_tdata[28], m_tdata[26:11] == 16'h0000)
    `HPRS_AST_NOW(a_drive_range, m_tvalid, m_tdata[10:0] != 11'h400 && m_tdata[31:29] == 3'b000)
endmodule

bind heading_pid_rotate_with_settle hprs_checker u_hprs_checker (.*);
`default_nettype wire
